// ===== design/star_blob_labeler_defines.svh =====
// assertion macros used by the star blob labeler back end
`ifndef STAR_BLOB_LABELER_DEFINES_SVH
`define STAR_BLOB_LABELER_DEFINES_SVH

`ifndef ASSERT_OFF

// condition must never hold at a clock edge
`define SBL_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define SBL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define SBL_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`define SBL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== design/sbl_pkg.sv =====
// types and constants shared by the star blob labeler modules
`timescale 1ns / 1ps

package sbl_pkg;

  // default sizing
  localparam int MAX_ROWS_DEF    = 4;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int LABEL_COUNT_DEF = 4096;

  // field widths
  localparam int COLUMN_W       = 10;
  localparam int ROW_W          = 12;
  localparam int INTENSITY_W    = 16;
  localparam int STAR_LABEL_W   = 12;
  localparam int ERR_W          = 2;
  localparam int SEARCH_ROWS_W  = 3;
  localparam int LINE_WIDTH_W   = 11;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 11;

  // register reset values
  localparam logic [SEARCH_ROWS_W-1:0] SEARCH_ROWS_RST = 3'd4;
  localparam logic [LINE_WIDTH_W-1:0]  LINE_WIDTH_RST  = 11'd1024;

  // command queue depth
  localparam int QUEUE_DEPTH = 2;

  // input mode codes
  localparam logic MODE_POINT = 1'b0;
  localparam logic MODE_EOL   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEARCH_ROWS = 1'b0,
    REG_LINE_WIDTH  = 1'b1
  } cfg_reg_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE   = 2'd0,
    ERR_COLUMN = 2'd1,
    ERR_LABELS = 2'd2
  } err_code_t;

  typedef enum logic [1:0] {
    CMD_POINT   = 2'd0,
    CMD_BAD_COL = 2'd1,
    CMD_EOL     = 2'd2
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH,
    ST_LINE_CLR
  } back_state_t;

  typedef enum logic [1:0] {
    SIDE_LEFT,
    SIDE_TOP,
    SIDE_RIGHT
  } ring_side_t;

  typedef struct packed {
    logic                   mode;
    logic [COLUMN_W-1:0]    column;
    logic [ROW_W-1:0]       row;
    logic [INTENSITY_W-1:0] intensity;
  } in_word_t;

  typedef struct packed {
    logic [STAR_LABEL_W-1:0] star_label;
    logic                    new_star;
    logic [COLUMN_W-1:0]     point_column;
    logic [ROW_W-1:0]        point_row;
    logic [INTENSITY_W-1:0]  point_intensity;
    logic [ERR_W-1:0]        error_code;
  } out_word_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [COLUMN_W-1:0]    column;
    logic [ROW_W-1:0]       row;
    logic [INTENSITY_W-1:0] intensity;
  } cmd_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_sts_t;

  typedef struct packed {
    logic clearing;
  } back_sts_t;

endpackage

// ===== design/sbl_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module sbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/sbl_front.sv =====
// front end: takes input words and classifies them into commands
`timescale 1ns / 1ps

module sbl_front #(
  parameter int MAX_WIDTH = sbl_pkg::MAX_WIDTH_DEF
) (
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sbl_pkg::in_word_t                   in_word,
  input  logic [sbl_pkg::LINE_WIDTH_W-1:0]    line_width,
  input  sbl_pkg::queue_sts_t                 q_sts,
  input  sbl_pkg::back_sts_t                  back_sts,
  output logic                                q_push,
  output sbl_pkg::cmd_t                       q_data
);

  localparam int MW_W = $clog2(MAX_WIDTH + 1);
  localparam int CX_W = (MW_W > sbl_pkg::COLUMN_W) ? MW_W : sbl_pkg::COLUMN_W;

  logic col_in_line;
  logic col_in_store;

  // hold off while the queue is full or the store is being cleared after reset
  assign in_stall = q_sts.full || back_sts.clearing;
  assign q_push   = in_valid && !in_stall;

  // column range checks against the line width and the store width
  assign col_in_line  = {1'b0, in_word.column} < line_width;
  assign col_in_store = CX_W'(in_word.column) < CX_W'(MAX_WIDTH);

  // classify the word
  always_comb begin
    q_data.column    = in_word.column;
    q_data.row       = in_word.row;
    q_data.intensity = in_word.intensity;
    if (in_word.mode == sbl_pkg::MODE_EOL) begin
      q_data.kind = sbl_pkg::CMD_EOL;
    end else if (col_in_line && col_in_store) begin
      q_data.kind = sbl_pkg::CMD_POINT;
    end else begin
      q_data.kind = sbl_pkg::CMD_BAD_COL;
    end
  end

endmodule

// ===== design/sbl_queue.sv =====
// short command queue between front and back end
`timescale 1ns / 1ps

module sbl_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sbl_pkg::cmd_t       wr_data,
  input  logic                pop,
  output sbl_pkg::cmd_t       rd_data,
  output sbl_pkg::queue_sts_t sts
);

  localparam int DEPTH = sbl_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  sbl_pkg::cmd_t   entry_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r,  count_nxt;
  logic            do_push, do_pop;

  assign do_push = push && (count_r != CW'(DEPTH));
  assign do_pop  = pop && (count_r != '0);

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data       = entry_r[rd_ptr_r];
  assign sts.not_empty = (count_r != '0);
  assign sts.full      = (count_r == CW'(DEPTH));

endmodule

// ===== design/sbl_back.sv =====
// back end: ring search sequencer, label allocation, row clearing, result register
`timescale 1ns / 1ps
`include "star_blob_labeler_defines.svh"

module sbl_back #(
  parameter int MAX_ROWS    = sbl_pkg::MAX_ROWS_DEF,
  parameter int MAX_WIDTH   = sbl_pkg::MAX_WIDTH_DEF,
  parameter int LABEL_COUNT = sbl_pkg::LABEL_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sbl_pkg::queue_sts_t                q_sts,
  input  sbl_pkg::cmd_t                      q_data,
  output logic                               q_pop,
  output sbl_pkg::back_sts_t                 sts,
  input  logic [sbl_pkg::SEARCH_ROWS_W-1:0]  search_rows,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sbl_pkg::out_word_t                 out_word
);

  localparam int NROWS = MAX_ROWS + 1;
  localparam int RW    = $clog2(NROWS);
  localparam int LV_W  = $clog2(MAX_ROWS + 1);
  localparam int KW    = $clog2(2 * MAX_ROWS);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int XW    = (COL_W > sbl_pkg::COLUMN_W) ? COL_W : sbl_pkg::COLUMN_W;
  localparam int PC_W  = XW + 2;
  localparam int AW    = RW + COL_W;
  localparam int DEPTH = NROWS << COL_W;
  localparam int LBL_W = $clog2(LABEL_COUNT);
  localparam int CELL_W = LBL_W + 1;
  localparam int NL_W  = $clog2(LABEL_COUNT + 1);
  localparam int SR_W  = sbl_pkg::SEARCH_ROWS_W;
  localparam int DC_W  = ((LV_W > SR_W) ? LV_W : SR_W) + 1;
  localparam int SLW   = sbl_pkg::STAR_LABEL_W;

  sbl_pkg::back_state_t state_r, state_nxt;
  sbl_pkg::cmd_t        cmd_r, cmd_nxt;
  sbl_pkg::ring_side_t  side_r, side_nxt;
  sbl_pkg::out_word_t   out_word_r, res;

  logic [RW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [LV_W-1:0]  depth_r, depth_nxt;
  logic [LV_W-1:0]  lv_r, lv_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic             gen_done_r, gen_done_nxt;
  logic             chk_v_r, chk_v_nxt;
  logic             found_r, found_nxt;
  logic [LBL_W-1:0] lab_r, lab_nxt;
  logic [NL_W-1:0]  next_label_r, next_label_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [LV_W-1:0]  depth_clamp;
  logic [LV_W-1:0]  probe_d;
  logic [PC_W-1:0]  probe_col;
  logic             probe_in;
  logic [RW:0]      phys_sum;
  logic [RW-1:0]    probe_row;
  logic             probe_last;
  sbl_pkg::ring_side_t adv_side;
  logic [KW-1:0]    adv_k;
  logic [LV_W-1:0]  adv_lv;

  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [CELL_W-1:0] wr_data, rd_data;
  logic             out_free, out_load;
  logic             res_store, res_fresh;
  logic [LBL_W-1:0] res_lab;
  logic             label_ok;

  // label line store: valid bit over label, rows addressed through a rotating head
  sbl_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // search depth clamped to one .. MAX_ROWS
  always_comb begin
    if (search_rows == '0) begin
      depth_clamp = LV_W'(1);
    end else if (DC_W'(search_rows) > DC_W'(MAX_ROWS)) begin
      depth_clamp = LV_W'(MAX_ROWS);
    end else begin
      depth_clamp = LV_W'(search_rows);
    end
  end

  // current probe position and the step to the next one
  always_comb begin
    probe_d    = lv_r;
    probe_col  = PC_W'(cmd_r.column) - PC_W'(lv_r);
    adv_side   = side_r;
    adv_k      = k_r + 1'b1;
    adv_lv     = lv_r;
    probe_last = 1'b0;
    unique case (side_r)
      sbl_pkg::SIDE_LEFT: begin
        probe_d   = LV_W'(k_r);
        probe_col = PC_W'(cmd_r.column) - PC_W'(lv_r);
        if (k_r == KW'(lv_r) - 1'b1) begin
          adv_side = sbl_pkg::SIDE_TOP;
          adv_k    = '0;
        end
      end
      sbl_pkg::SIDE_TOP: begin
        probe_d   = lv_r;
        probe_col = PC_W'(cmd_r.column) + PC_W'(k_r) - PC_W'(lv_r);
        // last top cell sits at offset lv-1, index 2*lv-1
        if (k_r == (KW'(lv_r) << 1) - 1'b1) begin
          adv_side = sbl_pkg::SIDE_RIGHT;
          adv_k    = KW'(lv_r);
        end
      end
      sbl_pkg::SIDE_RIGHT: begin
        probe_d   = LV_W'(k_r);
        probe_col = PC_W'(cmd_r.column) + PC_W'(lv_r);
        adv_k     = k_r - 1'b1;
        if (k_r == KW'(1)) begin
          adv_side = sbl_pkg::SIDE_LEFT;
          adv_k    = '0;
          adv_lv   = lv_r + 1'b1;
          probe_last = (lv_r == depth_r);
        end
      end
      default: begin
        probe_last = 1'b1;
      end
    endcase
  end

  // columns outside the store never hold a label, so they read empty without a memory access
  assign probe_in  = !probe_col[PC_W-1] && (probe_col < PC_W'(MAX_WIDTH));
  assign phys_sum  = (RW+1)'(head_r) + (RW+1)'(probe_d);
  assign probe_row = (phys_sum >= (RW+1)'(NROWS)) ? RW'(phys_sum - (RW+1)'(NROWS))
                                                  : RW'(phys_sum);
  assign rd_addr   = {probe_row, probe_col[COL_W-1:0]};

  // result word for the command in hand
  assign label_ok = next_label_r < NL_W'(LABEL_COUNT);

  always_comb begin
    res.point_column    = cmd_r.column;
    res.point_row       = cmd_r.row;
    res.point_intensity = cmd_r.intensity;
    res.star_label      = '0;
    res.new_star        = 1'b0;
    res.error_code      = sbl_pkg::ERR_NONE;
    res_store           = 1'b0;
    res_fresh           = 1'b0;
    res_lab             = lab_r;
    priority if (cmd_r.kind != sbl_pkg::CMD_POINT) begin
      res.error_code = sbl_pkg::ERR_COLUMN;
    end else if (found_r) begin
      res_store = 1'b1;
    end else if (label_ok) begin
      res_lab   = LBL_W'(next_label_r);
      res_store = 1'b1;
      res_fresh = 1'b1;
    end else begin
      res.error_code = sbl_pkg::ERR_LABELS;
    end
    if (res_store) begin
      res.star_label = SLW'(res_lab);
      res.new_star   = res_fresh;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    head_nxt       = head_r;
    clr_cnt_nxt    = clr_cnt_r;
    depth_nxt      = depth_r;
    lv_nxt         = lv_r;
    side_nxt       = side_r;
    k_nxt          = k_r;
    gen_done_nxt   = gen_done_r;
    chk_v_nxt      = 1'b0;
    found_nxt      = found_r;
    lab_nxt        = lab_r;
    next_label_nxt = next_label_r;
    q_pop          = 1'b0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = clr_cnt_r;
    wr_data        = '0;
    out_load       = 1'b0;
    unique case (state_r)
      sbl_pkg::ST_INIT_CLR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = sbl_pkg::ST_IDLE;
        end
      end
      sbl_pkg::ST_IDLE: begin
        if (q_sts.not_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_data;
          unique case (q_data.kind)
            sbl_pkg::CMD_EOL: begin
              // rows move up: the oldest physical row becomes the new current row
              head_nxt    = (head_r == '0) ? RW'(NROWS - 1) : head_r - 1'b1;
              clr_cnt_nxt = '0;
              state_nxt   = sbl_pkg::ST_LINE_CLR;
            end
            sbl_pkg::CMD_BAD_COL: begin
              state_nxt = sbl_pkg::ST_FINISH;
            end
            sbl_pkg::CMD_POINT: begin
              depth_nxt    = depth_clamp;
              lv_nxt       = LV_W'(1);
              side_nxt     = sbl_pkg::SIDE_LEFT;
              k_nxt        = '0;
              gen_done_nxt = 1'b0;
              found_nxt    = 1'b0;
              state_nxt    = sbl_pkg::ST_SEARCH;
            end
            default: begin
              state_nxt = sbl_pkg::ST_IDLE;
            end
          endcase
        end
      end
      sbl_pkg::ST_SEARCH: begin
        priority if (chk_v_r && rd_data[LBL_W]) begin
          found_nxt = 1'b1;
          lab_nxt   = rd_data[LBL_W-1:0];
          state_nxt = sbl_pkg::ST_FINISH;
        end else if (gen_done_r) begin
          found_nxt = 1'b0;
          state_nxt = sbl_pkg::ST_FINISH;
        end else begin
          // issue one probe, checked on the next cycle
          rd_en        = probe_in;
          chk_v_nxt    = probe_in;
          side_nxt     = adv_side;
          k_nxt        = adv_k;
          lv_nxt       = adv_lv;
          gen_done_nxt = probe_last;
        end
      end
      sbl_pkg::ST_FINISH: begin
        if (out_free) begin
          out_load  = 1'b1;
          wr_en     = res_store;
          wr_addr   = {head_r, COL_W'(cmd_r.column)};
          wr_data   = {1'b1, res_lab};
          if (res_fresh) begin
            next_label_nxt = next_label_r + 1'b1;
          end
          state_nxt = sbl_pkg::ST_IDLE;
        end
      end
      sbl_pkg::ST_LINE_CLR: begin
        wr_en       = 1'b1;
        wr_addr     = {head_r, clr_cnt_r[COL_W-1:0]};
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r[COL_W-1:0] == COL_W'(MAX_WIDTH - 1)) begin
          state_nxt = sbl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sbl_pkg::ST_INIT_CLR;
      end
    endcase
  end

  // result register valid
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sbl_pkg::ST_INIT_CLR;
      head_r       <= '0;
      clr_cnt_r    <= '0;
      gen_done_r   <= 1'b0;
      chk_v_r      <= 1'b0;
      next_label_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      gen_done_r   <= gen_done_nxt;
      chk_v_r      <= chk_v_nxt;
      next_label_r <= next_label_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    depth_r <= depth_nxt;
    lv_r    <= lv_nxt;
    side_r  <= side_nxt;
    k_r     <= k_nxt;
    found_r <= found_nxt;
    lab_r   <= lab_nxt;
    if (out_load) begin
      out_word_r <= res;
    end
  end

  assign sts.clearing = (state_r == sbl_pkg::ST_INIT_CLR);
  assign out_valid    = out_valid_r;
  assign out_word     = out_word_r;

  // checks
  `SBL_ASSERT_NEVER(a_rd_wr_excl, clk, rst_n, rd_en && wr_en, "store read during a write")
  `SBL_ASSERT_NEVER(a_out_overrun, clk, rst_n, out_load && out_valid_r && out_stall, "result overwritten while stalled")
  `SBL_ASSERT_NEXT(a_fresh_count, clk, rst_n, out_load && res_fresh, next_label_r == $past(next_label_r) + 1'b1, "fresh label without counter step")
  `SBL_ASSERT_NEVER(a_label_bound, clk, rst_n, next_label_r > NL_W'(LABEL_COUNT), "label counter past its limit")

endmodule

// ===== design/star_blob_labeler.sv =====
// top level of the star blob labeler: config registers, front end, queue, back end
//
//   port group   dir   handshake            word
//   in_*         in    in_valid / in_stall  sbl_pkg::in_word_t (mode, column, row, intensity)
//   out_*        out   out_valid/out_stall  sbl_pkg::out_word_t (label, flags, echoes, error)
//   cfg_*        in    cfg_we               cfg_idx selects register, cfg_wdata holds value
//
// a bright point is searched ring by ring out to d, the clamped search depth, with at most
// one store read per ring cell, until a labelled cell is found; a bad column skips the search
// an end of line clears the new current row, one store write per column
// after reset the store is cleared once, all (MAX_ROWS+1)*2^clog2(MAX_WIDTH) words (5120),
// with in_stall high; configuration writes are taken meanwhile
// a two word command queue lets input continue while a result waits on out_stall
`timescale 1ns / 1ps

module star_blob_labeler #(
  parameter int MAX_ROWS    = sbl_pkg::MAX_ROWS_DEF,
  parameter int MAX_WIDTH   = sbl_pkg::MAX_WIDTH_DEF,
  parameter int LABEL_COUNT = sbl_pkg::LABEL_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  sbl_pkg::in_word_t                in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output sbl_pkg::out_word_t               out_word,
  input  logic                             cfg_we,
  input  logic [sbl_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [sbl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [sbl_pkg::SEARCH_ROWS_W-1:0] search_rows_r, search_rows_nxt;
  logic [sbl_pkg::LINE_WIDTH_W-1:0]  line_width_r,  line_width_nxt;

  sbl_pkg::queue_sts_t q_sts;
  sbl_pkg::back_sts_t  back_sts;
  sbl_pkg::cmd_t       push_data, pop_data;
  logic                q_push, q_pop;

  // configuration register writes
  always_comb begin
    search_rows_nxt = search_rows_r;
    line_width_nxt  = line_width_r;
    if (cfg_we) begin
      unique case (sbl_pkg::cfg_reg_t'(cfg_idx))
        sbl_pkg::REG_SEARCH_ROWS: search_rows_nxt = cfg_wdata[sbl_pkg::SEARCH_ROWS_W-1:0];
        sbl_pkg::REG_LINE_WIDTH:  line_width_nxt  = cfg_wdata[sbl_pkg::LINE_WIDTH_W-1:0];
        default: begin
          search_rows_nxt = search_rows_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_rows_r <= sbl_pkg::SEARCH_ROWS_RST;
      line_width_r  <= sbl_pkg::LINE_WIDTH_RST;
    end else begin
      search_rows_r <= search_rows_nxt;
      line_width_r  <= line_width_nxt;
    end
  end

  // input classification
  sbl_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .line_width (line_width_r),
    .q_sts      (q_sts),
    .back_sts   (back_sts),
    .q_push     (q_push),
    .q_data     (push_data)
  );

  // command queue
  sbl_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (push_data),
    .pop     (q_pop),
    .rd_data (pop_data),
    .sts     (q_sts)
  );

  // search, labeling and result output
  sbl_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_WIDTH   (MAX_WIDTH),
    .LABEL_COUNT (LABEL_COUNT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_sts       (q_sts),
    .q_data      (pop_data),
    .q_pop       (q_pop),
    .sts         (back_sts),
    .search_rows (search_rows_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

endmodule
